// File: hdl/sti_pkg.sv
// ----------------------------------------------------------------------------
// sti_pkg: shared types for the segment versus triangle intersection block
// Holds the packed item and result layouts used on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

package sti_pkg;

  localparam int FIELD_BITS = 63;

  typedef struct packed {
    logic [FIELD_BITS-1:0] seg_start;
    logic [FIELD_BITS-1:0] seg_end;
    logic [FIELD_BITS-1:0] vertex_a;
    logic [FIELD_BITS-1:0] vertex_b;
    logic [FIELD_BITS-1:0] vertex_c;
    logic [FIELD_BITS-1:0] plane_normal;
  } item_t;

  typedef struct packed {
    logic                  hit;
    logic [FIELD_BITS-1:0] meet_point;
  } result_t;

endpackage

`default_nettype wire

// File: hdl/sti_div.sv
// ----------------------------------------------------------------------------
// sti_div: pipelined unsigned restoring divider
// One quotient bit per register stage, most significant first. The caller
// guarantees that the quotient fits in QW bits.
// ----------------------------------------------------------------------------
`default_nettype none

module sti_div #(
  parameter int PW = 67,
  parameter int NW = 45,
  parameter int QW = 22
) (
  input  wire logic          clk,
  input  wire logic [PW-1:0] dividend,
  input  wire logic [NW-1:0] divisor,
  output logic      [QW-1:0] quot,
  output logic      [NW-1:0] rem
);

  logic [PW-1:0] rem_q [QW];
  logic [NW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [PW-1:0] rem_in;
    logic [NW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [PW:0]   trial;

    if (j == 0) begin : g_first
      assign rem_in = dividend;
      assign den_in = divisor;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign den_in = den_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    assign trial = {1'b0, rem_in} - ((PW+1)'(den_in) << (QW-1-j));

    always_ff @(posedge clk) begin
      den_q[j] <= den_in;
      if (!trial[PW]) begin
        rem_q[j] <= trial[PW-1:0];
        quo_q[j] <= quo_in | (QW'(1) << (QW-1-j));
      end else begin
        rem_q[j] <= rem_in;
        quo_q[j] <= quo_in;
      end
    end
  end

  assign quot = quo_q[QW-1];
  // The final remainder is below the divisor, so its upper bits are zero.
  assign rem  = rem_q[QW-1][NW-1:0];

endmodule

`default_nettype wire

// File: hdl/segment_triangle_intersect.sv
// ----------------------------------------------------------------------------
// segment_triangle_intersect: pipelined segment versus triangle test
//
//   Channel  Ports                 Transfer when
//   input    start, busy, item     rising edge with start high, busy low
//   output   done, result          rising edge ending the cycle done is high
//
// One item is taken every cycle; busy is always low. The one-bit-per-stage
// divider that places the meeting point (QW = COORD_BITS + 1 stages) sits
// around the multiply and sum stages. Reset clears only the valid bits;
// results leave in the order items came in and cannot be held off by the
// receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_triangle_intersect #(
  parameter int COORD_BITS = 21
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire sti_pkg::item_t  item,
  output logic                 done,
  output sti_pkg::result_t     result
);

  localparam int C   = COORD_BITS;
  localparam int DW  = C + 1;          // coordinate differences
  localparam int PRW = 2 * C + 1;      // single products of the plane dots
  localparam int NW  = 2 * C + 3;      // num and den
  localparam int XW  = 2 * C + 2;      // edge cross normal components
  localparam int LH  = (NW + 1) / 2;
  localparam int HH  = NW - LH;
  localparam int PW  = DW + NW;        // |d| * |num|
  localparam int QW  = DW;
  localparam int VW  = C + 1;          // point minus vertex
  localparam int XL  = XW / 2;
  localparam int XH  = XW - XL;
  localparam int LOW = VW + XL + 1;
  localparam int HIW = VW + XH;
  localparam int FW  = VW + XW;
  localparam int SW  = FW + 2;

  typedef logic signed [C-1:0]  crd_t;
  typedef logic signed [XW-1:0] crs_t;

  typedef struct packed {
    logic          ok;
    logic [2:0]    neg;
    logic [NW-1:0] ad;
    crd_t [2:0]    s;
    crd_t [2:0]    a;
    crd_t [2:0]    b;
    crd_t [2:0]    c;
    crs_t [2:0]    x0;
    crs_t [2:0]    x1;
    crs_t [2:0]    x2;
  } side_t;

  assign busy = 1'b0;

  // ---------------------------------------------------------------- stage 1
  logic                  vld1;
  crd_t                  s1 [3], a1 [3], b1 [3], c1 [3], n1 [3];
  logic signed [DW-1:0]  d1 [3], w1 [3], eab1 [3], ebc1 [3], eca1 [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s1[i]   <= $signed(item.seg_start[i*C +: C]);
      a1[i]   <= $signed(item.vertex_a[i*C +: C]);
      b1[i]   <= $signed(item.vertex_b[i*C +: C]);
      c1[i]   <= $signed(item.vertex_c[i*C +: C]);
      n1[i]   <= $signed(item.plane_normal[i*C +: C]);
      d1[i]   <= DW'($signed(item.seg_end[i*C +: C])) - DW'($signed(item.seg_start[i*C +: C]));
      w1[i]   <= DW'($signed(item.vertex_a[i*C +: C])) - DW'($signed(item.seg_start[i*C +: C]));
      eab1[i] <= DW'($signed(item.vertex_b[i*C +: C])) - DW'($signed(item.vertex_a[i*C +: C]));
      ebc1[i] <= DW'($signed(item.vertex_c[i*C +: C])) - DW'($signed(item.vertex_b[i*C +: C]));
      eca1[i] <= DW'($signed(item.vertex_a[i*C +: C])) - DW'($signed(item.vertex_c[i*C +: C]));
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic                  vld2;
  crd_t                  s2 [3], a2 [3], b2 [3], c2 [3];
  logic signed [DW-1:0]  d2 [3];
  logic signed [PRW-1:0] pd2 [3], pw2 [3];
  logic signed [PRW-1:0] xp2 [3][6];
  logic signed [DW-1:0]  edg [3][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      edg[0][i] = eab1[i];
      edg[1][i] = ebc1[i];
      edg[2][i] = eca1[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s2[i]  <= s1[i];
      a2[i]  <= a1[i];
      b2[i]  <= b1[i];
      c2[i]  <= c1[i];
      d2[i]  <= d1[i];
      pd2[i] <= PRW'(n1[i]) * PRW'(d1[i]);
      pw2[i] <= PRW'(n1[i]) * PRW'(w1[i]);
    end
    for (int k = 0; k < 3; k++) begin
      xp2[k][0] <= PRW'(edg[k][1]) * PRW'(n1[2]);
      xp2[k][1] <= PRW'(edg[k][2]) * PRW'(n1[1]);
      xp2[k][2] <= PRW'(edg[k][2]) * PRW'(n1[0]);
      xp2[k][3] <= PRW'(edg[k][0]) * PRW'(n1[2]);
      xp2[k][4] <= PRW'(edg[k][0]) * PRW'(n1[1]);
      xp2[k][5] <= PRW'(edg[k][1]) * PRW'(n1[0]);
    end
  end

  // ---------------------------------------------------------------- stage 3
  logic                  vld3;
  crd_t                  s3 [3], a3 [3], b3 [3], c3 [3];
  logic signed [DW-1:0]  d3 [3];
  logic signed [NW-1:0]  den3, num3;
  crs_t                  x3 [3][3];

  always_ff @(posedge clk) begin
    den3 <= NW'(pd2[0]) + NW'(pd2[1]) + NW'(pd2[2]);
    num3 <= NW'(pw2[0]) + NW'(pw2[1]) + NW'(pw2[2]);
    for (int i = 0; i < 3; i++) begin
      s3[i] <= s2[i];
      a3[i] <= a2[i];
      b3[i] <= b2[i];
      c3[i] <= c2[i];
      d3[i] <= d2[i];
    end
    for (int k = 0; k < 3; k++) begin
      x3[k][0] <= XW'(xp2[k][0]) - XW'(xp2[k][1]);
      x3[k][1] <= XW'(xp2[k][2]) - XW'(xp2[k][3]);
      x3[k][2] <= XW'(xp2[k][4]) - XW'(xp2[k][5]);
    end
  end

  // ---------------------------------------------------------------- stage 4
  logic                  vld4, ok4;
  logic [2:0]            neg4;
  logic [NW-1:0]         ad4, an4;
  logic [DW-1:0]         dm4 [3];
  crd_t                  s4 [3], a4 [3], b4 [3], c4 [3];
  crs_t                  x4 [3][3];
  logic                  ok3;

  always_comb begin
    if (den3 > 0) begin
      ok3 = (num3 >= 0) && (num3 <= den3);
    end else if (den3 < 0) begin
      ok3 = (num3 <= 0) && (num3 >= den3);
    end else begin
      ok3 = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    ok4 <= ok3;
    ad4 <= den3[NW-1] ? NW'(-den3) : NW'(den3);
    an4 <= num3[NW-1] ? NW'(-num3) : NW'(num3);
    for (int i = 0; i < 3; i++) begin
      neg4[i] <= d3[i][DW-1] ^ num3[NW-1] ^ den3[NW-1];
      dm4[i]  <= d3[i][DW-1] ? DW'(-d3[i]) : DW'(d3[i]);
      s4[i]   <= s3[i];
      a4[i]   <= a3[i];
      b4[i]   <= b3[i];
      c4[i]   <= c3[i];
      for (int k = 0; k < 3; k++) begin
        x4[k][i] <= x3[k][i];
      end
    end
  end

  // ---------------------------------------------------------------- stage 5
  logic                  vld5, ok5;
  logic [2:0]            neg5;
  logic [NW-1:0]         ad5;
  logic [DW+LH-1:0]      plo5 [3];
  logic [DW+HH-1:0]      phi5 [3];
  crd_t                  s5 [3], a5 [3], b5 [3], c5 [3];
  crs_t                  x5 [3][3];

  always_ff @(posedge clk) begin
    ok5  <= ok4;
    neg5 <= neg4;
    ad5  <= ad4;
    for (int i = 0; i < 3; i++) begin
      plo5[i] <= (DW+LH)'(dm4[i]) * (DW+LH)'(an4[LH-1:0]);
      phi5[i] <= (DW+HH)'(dm4[i]) * (DW+HH)'(an4[NW-1:LH]);
      s5[i]   <= s4[i];
      a5[i]   <= a4[i];
      b5[i]   <= b4[i];
      c5[i]   <= c4[i];
      for (int k = 0; k < 3; k++) begin
        x5[k][i] <= x4[k][i];
      end
    end
  end

  // ---------------------------------------------------------------- stage 6
  logic                  vld6;
  logic [PW-1:0]         prod6 [3];
  side_t                 side6;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      prod6[i]    <= (PW'(phi5[i]) << LH) + PW'(plo5[i]);
      side6.s[i]  <= s5[i];
      side6.a[i]  <= a5[i];
      side6.b[i]  <= b5[i];
      side6.c[i]  <= c5[i];
      side6.x0[i] <= x5[0][i];
      side6.x1[i] <= x5[1][i];
      side6.x2[i] <= x5[2][i];
    end
    side6.ok  <= ok5;
    side6.neg <= neg5;
    side6.ad  <= ad5;
  end

  // ------------------------------------------------------------ divider lanes
  logic [QW-1:0]         quo [3];
  logic [NW-1:0]         rmd [3];
  side_t                 side_q [QW];
  logic [QW-1:0]         vld_div;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    sti_div #(
      .PW (PW),
      .NW (NW),
      .QW (QW)
    ) u_div (
      .clk      (clk),
      .dividend (prod6[i]),
      .divisor  (side6.ad),
      .quot     (quo[i]),
      .rem      (rmd[i])
    );
  end

  always_ff @(posedge clk) begin
    side_q[0] <= side6;
    for (int k = 1; k < QW; k++) begin
      side_q[k] <= side_q[k-1];
    end
  end

  // ---------------------------------------------------------------- stage 7
  side_t                 sd;
  logic                  vld7, ok7;
  crd_t                  p7 [3], a7 [3], b7 [3], c7 [3];
  crs_t                  x7 [3][3];
  logic [DW-1:0]         qr [3];
  logic signed [C+1:0]   ps [3];

  assign sd = side_q[QW-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // Round to nearest, ties away from zero.
      qr[i] = quo[i] + DW'({rmd[i], 1'b0} >= {1'b0, sd.ad});
      if (sd.neg[i]) begin
        ps[i] = (C+2)'(sd.s[i]) - $signed((C+2)'(qr[i]));
      end else begin
        ps[i] = (C+2)'(sd.s[i]) + $signed((C+2)'(qr[i]));
      end
    end
  end

  always_ff @(posedge clk) begin
    ok7 <= sd.ok;
    for (int i = 0; i < 3; i++) begin
      p7[i]    <= ps[i][C-1:0];
      a7[i]    <= sd.a[i];
      b7[i]    <= sd.b[i];
      c7[i]    <= sd.c[i];
      x7[0][i] <= sd.x0[i];
      x7[1][i] <= sd.x1[i];
      x7[2][i] <= sd.x2[i];
    end
  end

  // ---------------------------------------------------------------- stage 8
  logic                  vld8, ok8;
  crd_t                  p8 [3];
  logic signed [VW-1:0]  v8 [3][3];
  crs_t                  x8 [3][3];

  always_ff @(posedge clk) begin
    ok8 <= ok7;
    for (int i = 0; i < 3; i++) begin
      p8[i]    <= p7[i];
      v8[0][i] <= VW'(p7[i]) - VW'(a7[i]);
      v8[1][i] <= VW'(p7[i]) - VW'(b7[i]);
      v8[2][i] <= VW'(p7[i]) - VW'(c7[i]);
      for (int k = 0; k < 3; k++) begin
        x8[k][i] <= x7[k][i];
      end
    end
  end

  // ---------------------------------------------------------------- stage 9
  // The wide edge term is split into a low unsigned and a high signed half.
  logic                  vld9, ok9;
  crd_t                  p9 [3];
  logic signed [LOW-1:0] lo9 [3][3];
  logic signed [HIW-1:0] hi9 [3][3];

  always_ff @(posedge clk) begin
    ok9 <= ok8;
    for (int i = 0; i < 3; i++) begin
      p9[i] <= p8[i];
      for (int k = 0; k < 3; k++) begin
        lo9[k][i] <= LOW'(v8[k][i]) * $signed(LOW'({1'b0, x8[k][i][XL-1:0]}));
        hi9[k][i] <= HIW'(v8[k][i]) * HIW'($signed(x8[k][i][XW-1:XL]));
      end
    end
  end

  // --------------------------------------------------------------- stage 10
  logic                  vld10, ok10;
  crd_t                  p10 [3];
  logic signed [FW-1:0]  f10 [3][3];

  always_ff @(posedge clk) begin
    ok10 <= ok9;
    for (int i = 0; i < 3; i++) begin
      p10[i] <= p9[i];
      for (int k = 0; k < 3; k++) begin
        f10[k][i] <= (FW'(hi9[k][i]) <<< XL) + FW'(lo9[k][i]);
      end
    end
  end

  // ------------------------------------------------------------ output stage
  logic signed [SW-1:0]  esum [3];
  logic                  outside;

  always_comb begin
    outside = 1'b0;
    for (int k = 0; k < 3; k++) begin
      esum[k] = SW'(f10[k][0]) + SW'(f10[k][1]) + SW'(f10[k][2]);
      if (esum[k] > 0) begin
        outside = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    result.hit <= ok10 && !outside;
    if (ok10 && !outside) begin
      result.meet_point <= sti_pkg::FIELD_BITS'({p10[2], p10[1], p10[0]});
    end else begin
      result.meet_point <= '0;
    end
  end

  // -------------------------------------------------------------- valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      vld3    <= 1'b0;
      vld4    <= 1'b0;
      vld5    <= 1'b0;
      vld6    <= 1'b0;
      vld_div <= '0;
      vld7    <= 1'b0;
      vld8    <= 1'b0;
      vld9    <= 1'b0;
      vld10   <= 1'b0;
      done    <= 1'b0;
    end else begin
      vld1    <= start && !busy;
      vld2    <= vld1;
      vld3    <= vld2;
      vld4    <= vld3;
      vld5    <= vld4;
      vld6    <= vld5;
      vld_div <= {vld_div[QW-2:0], vld6};
      vld7    <= vld_div[QW-1];
      vld8    <= vld7;
      vld9    <= vld8;
      vld10   <= vld9;
      done    <= vld10;
    end
  end

endmodule

`default_nettype wire
